>>> hdl/assert_macros.svh
// assertion helpers for the rtl (included by two_stacks_shared_memory)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rstn, prop) \
	label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
		else $error("assertion failed");

// consequence that must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rstn, prop)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

>>> hdl/tssm_pkg.sv
package tssm_pkg;

	localparam int DATA_W    = 32;
	localparam int DEPTH_DEF = 16;

	localparam logic [1:0] ACT_PUSH = 2'd0;
	localparam logic [1:0] ACT_POP  = 2'd1;
	localparam logic [1:0] ACT_PEEK = 2'd2;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
	localparam logic [1:0] STAT_UNDERFLOW = 2'd2;

	typedef enum logic {
		S_IDLE,
		S_RESP
	} state_t;

endpackage

>>> hdl/tssm_ram.sv
module tssm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// read data holds until the next read
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/two_stacks_shared_memory.sv
// two lifo stacks sharing one memory of DEPTH words
// the front stack grows upward from entry 0, the rear stack downward from the last entry
// input channel (in_valid / in_ready): one request of action, side and value
//   action push, pop or peek; side 0 front, 1 rear; value is used by push only
// output channel (out_valid / out_ready): one result per request, data, status and full_res
//   status ok, overflow (push into a full memory) or underflow (pop or peek on empty side)
//   data is the popped or peeked word, zero otherwise; full_res is set when both stacks
//   together fill the memory after the request
// status and read data are registered when the request is accepted and then moved into
//   the output register once it is free; no new request is taken before then, since
//   in_ready is low in the cycle the result is formed
// when the receiver stalls the result waits in the output register; one more request is
//   still accepted, its result is formed once the output register has been taken
// reset: both stacks empty and the output idle, at once; memory contents are not cleared
//   and need no clearing pass, since only written entries are ever read
module two_stacks_shared_memory
	import tssm_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               action,
	input  logic                     side,
	input  logic signed [DATA_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] data,
	output logic [1:0]               status,
	output logic                     full_res
);

`include "assert_macros.svh"

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);

	state_t state_q, state_d;

	logic [CW-1:0] front_q, rear_q, front_d, rear_d;
	logic [CW-1:0] used, used_d, cnt_sel, addr_w;
	logic          in_acc, load_out;

	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [DATA_W-1:0] ram_rdata;

	logic [1:0] stat_d, stat_q;
	logic       rd_ok_d, rd_ok_q, full_q;

	logic                     out_valid_q;
	logic signed [DATA_W-1:0] data_q;
	logic [1:0]               status_q;
	logic                     full_res_q;

	assign in_acc  = in_valid & in_ready;
	assign used    = front_q + rear_q;
	assign cnt_sel = side ? rear_q : front_q;

	// request decode and counter update
	always_comb begin
		front_d = front_q;
		rear_d  = rear_q;
		stat_d  = STAT_OK;
		rd_ok_d = 1'b0;
		ram_we  = 1'b0;
		ram_re  = 1'b0;
		addr_w  = '0;
		case (action)
			ACT_PUSH: begin
				if (used == CW'(DEPTH)) begin
					stat_d = STAT_OVERFLOW;
				end else if (!side) begin
					ram_we  = in_acc;
					addr_w  = front_q;
					front_d = front_q + CW'(1);
				end else begin
					ram_we = in_acc;
					addr_w = CW'(DEPTH - 1) - rear_q;
					rear_d = rear_q + CW'(1);
				end
			end
			ACT_POP, ACT_PEEK: begin
				if (cnt_sel == '0) begin
					stat_d = STAT_UNDERFLOW;
				end else begin
					rd_ok_d = 1'b1;
					ram_re  = in_acc;
					addr_w  = side ? (CW'(DEPTH) - rear_q) : (front_q - CW'(1));
					if (action == ACT_POP) begin
						if (side) begin
							rear_d = rear_q - CW'(1);
						end else begin
							front_d = front_q - CW'(1);
						end
					end
				end
			end
			default: begin
			end
		endcase
		used_d = front_d + rear_d;
	end

	assign ram_waddr = addr_w[AW-1:0];
	assign ram_raddr = addr_w[AW-1:0];

	tssm_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(value),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		load_out = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				// memory read data is held, so the result may wait for the output register
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			rear_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				front_q <= front_d;
				rear_q  <= rear_d;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			stat_q  <= stat_d;
			rd_ok_q <= rd_ok_d;
			full_q  <= (used_d == CW'(DEPTH));
		end
		if (load_out) begin
			data_q     <= rd_ok_q ? ram_rdata : '0;
			status_q   <= stat_q;
			full_res_q <= full_q;
		end
	end

	assign out_valid = out_valid_q;
	assign data      = data_q;
	assign status    = status_q;
	assign full_res  = full_res_q;

	`ASSERT_ALWAYS(a_used_in_range, clk, arst_n, used <= CW'(DEPTH))
	`ASSERT_ALWAYS(a_no_accept_in_resp, clk, arst_n, !(state_q == S_RESP && in_ready))
	`ASSERT_NEXT(a_accept_to_resp, clk, arst_n, in_acc, state_q == S_RESP)
	`ASSERT_ALWAYS(a_overflow_is_full, clk, arst_n,
		!(out_valid_q && status_q == STAT_OVERFLOW) || full_res_q)

endmodule

>>> test/tssm_checker.sv
`timescale 1ns / 100ps

module tssm_checker
	import tssm_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  logic [1:0]               action,
	input  logic                     side,
	input  logic signed [DATA_W-1:0] value,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  logic signed [DATA_W-1:0] data,
	input  logic [1:0]               status,
	input  logic                     full_res,
	output int                       mismatches,
	output int                       pending,
	output int                       checked,
	output int                       overflows,
	output int                       underflows,
	output int                       full_hits
);

	typedef struct {
		logic signed [DATA_W-1:0] data;
		logic [1:0]               status;
		logic                     full;
	} stack_result_t;

	stack_result_t            expected_results[$];
	stack_result_t            want;
	logic signed [DATA_W-1:0] words [DEPTH];
	int                       front_level;
	int                       rear_level;

	function automatic stack_result_t stack_op(logic [1:0] act, logic sd,
			logic signed [DATA_W-1:0] val);
		stack_result_t r;
		int            level;
		r.data   = '0;
		r.status = STAT_OK;
		if (act == ACT_PUSH) begin
			if (front_level + rear_level >= DEPTH) begin
				r.status = STAT_OVERFLOW;
			end else if (!sd) begin
				words[front_level] = val;
				front_level++;
			end else begin
				words[DEPTH - 1 - rear_level] = val;
				rear_level++;
			end
		end else if (act == ACT_POP || act == ACT_PEEK) begin
			level = sd ? rear_level : front_level;
			if (level == 0) begin
				r.status = STAT_UNDERFLOW;
			end else begin
				r.data = sd ? words[DEPTH - rear_level] : words[front_level - 1];
				if (act == ACT_POP) begin
					if (sd) rear_level--;
					else front_level--;
				end
			end
		end
		r.full = (front_level + rear_level == DEPTH);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_results.delete();
			front_level = 0;
			rear_level  = 0;
			mismatches  = 0;
			pending     = 0;
			checked     = 0;
			overflows   = 0;
			underflows  = 0;
			full_hits   = 0;
		end else begin
			// result side first: a request accepted at this edge cannot answer yet
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result with no request waiting: data %0d status %0d full %0d",
							$realtime, data, status, full_res);
				end else begin
					want = expected_results.pop_front();
					checked++;
					if (want.status == STAT_OVERFLOW) overflows++;
					if (want.status == STAT_UNDERFLOW) underflows++;
					if (want.full) full_hits++;
					if (data !== want.data || status !== want.status || full_res !== want.full) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: mismatch: expected data %0d status %0d full %0d, got data %0d status %0d full %0d",
								$realtime, want.data, want.status, want.full, data, status, full_res);
					end
				end
			end
			if (in_valid && in_ready)
				expected_results.push_back(stack_op(action, side, value));
			pending = expected_results.size();
		end
	end

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;
	import tssm_pkg::*;

	localparam int WATCHDOG_LIMIT  = 5000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int PHASE_ITEMS     = 440;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     in_valid  = 1'b0;
	logic [1:0]               action    = ACT_PUSH;
	logic                     side      = 1'b0;
	logic signed [DATA_W-1:0] value     = '0;
	logic                     out_ready = 1'b0;
	logic                     in_ready;
	logic                     out_valid;
	logic signed [DATA_W-1:0] data;
	logic [1:0]               status;
	logic                     full_res;

	int idle_pct  = 0;
	int stall_pct = 0;
	bit hold_off_req = 1'b0;
	int hold_left    = 0;
	int quiet_cycles = 0;
	int mismatches, pending, checked, overflows, underflows, full_hits;

	two_stacks_shared_memory #(.DEPTH(DEPTH_DEF)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .side(side), .value(value),
		.out_valid(out_valid), .out_ready(out_ready),
		.data(data), .status(status), .full_res(full_res)
	);

	tssm_checker #(.DEPTH(DEPTH_DEF)) stack_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .side(side), .value(value),
		.out_valid(out_valid), .out_ready(out_ready),
		.data(data), .status(status), .full_res(full_res),
		.mismatches(mismatches), .pending(pending), .checked(checked),
		.overflows(overflows), .underflows(underflows), .full_hits(full_hits)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// receiver: random stalls, or one long hold-off when asked
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (hold_off_req) begin
			hold_off_req = 1'b0;
			hold_left    = HOLD_OFF_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	function automatic logic signed [DATA_W-1:0] pick_word();
		case ($urandom_range(9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	// called just after a rising edge; returns at the edge that takes the request
	task automatic send_req(input logic [1:0] act, input logic sd,
			input logic signed [DATA_W-1:0] val);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		in_valid <= 1'b1;
		action   <= act;
		side     <= sd;
		value    <= val;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
	endtask

	// push-heavy and pop-heavy stretches alternate so both full and empty come round
	task automatic random_phase(input int count);
		int         i;
		int         push_pct;
		int         rear_pct;
		logic [1:0] act;
		logic       sd;
		push_pct = 75;
		rear_pct = 50;
		for (i = 0; i < count; i++) begin
			if (i % 32 == 0) begin
				push_pct = ((i / 32) % 2) ? 25 : 75;
				rear_pct = $urandom_range(85, 15);
			end
			if ($urandom_range(99) < push_pct) act = ACT_PUSH;
			else act = ($urandom_range(99) < 60) ? ACT_POP : ACT_PEEK;
			sd = ($urandom_range(99) < rear_pct);
			send_req(act, sd, pick_word());
		end
	endtask

	initial begin
		int k;
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(posedge clk);

		// empty sides, extreme words, then fill the memory and push past it
		send_req(ACT_POP, 1'b0, pick_word());
		send_req(ACT_PEEK, 1'b1, pick_word());
		send_req(ACT_PUSH, 1'b0, 32'sh7fffffff);
		send_req(ACT_PUSH, 1'b1, 32'sh80000000);
		send_req(ACT_PEEK, 1'b0, pick_word());
		send_req(ACT_PEEK, 1'b1, pick_word());
		send_req(ACT_POP, 1'b0, pick_word());
		send_req(ACT_POP, 1'b1, pick_word());
		for (k = 0; k < DEPTH_DEF; k++)
			send_req(ACT_PUSH, k[0], (k % 4 == 0) ? '0 : (k % 4 == 1) ? '1 : pick_word());
		send_req(ACT_PUSH, 1'b0, pick_word());
		send_req(ACT_PUSH, 1'b1, pick_word());
		drain();

		// long receiver hold-off while requests keep coming
		hold_off_req = 1'b1;
		random_phase(PHASE_ITEMS);
		drain();

		idle_pct  = 61;
		random_phase(PHASE_ITEMS);
		drain();

		idle_pct  = 0;
		stall_pct = 61;
		random_phase(PHASE_ITEMS);
		drain();

		idle_pct  = 18;
		stall_pct = 18;
		random_phase(PHASE_ITEMS - 10);
		drain();
		repeat (4) @(posedge clk);

		$display("checked %0d results: %0d overflows, %0d underflows, %0d with memory full",
			checked, overflows, underflows, full_hits);
		$display("covered free-running, sender gaps, receiver stalls, both, and a %0d-cycle hold-off",
			HOLD_OFF_CYCLES);
		if (mismatches == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
